FILE: rtl/ncm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncm_pkg
// Types and constants shared by the normalization cube map texel pipeline.
// ----------------------------------------------------------------------------
package ncm_pkg;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  localparam logic [10:0] SIZE_RESET = 11'd32;
  localparam logic [15:0] AXIS_ONE   = 16'h8000;
  localparam int          DIV_CELLS  = 15;
  localparam int          RSQ_CELLS  = 17;

  typedef struct packed {
    logic [11:0] rem;
    logic [14:0] q;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] size;
    logic [2:0]  face;
    logic        bad;
    div_lane_t   sc;
    div_lane_t   tc;
  } div_stage_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [31:0]      m;
    logic [62:0]      p;
    logic [49:0]      rm;
    logic [16:0]      r;
  } rsq_stage_t;

endpackage
`default_nettype wire

FILE: rtl/ncm_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncm_div_cell
// One restoring division step for both texel center coordinates.
// ----------------------------------------------------------------------------
module ncm_div_cell
  import ncm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  div_stage_t din,
  output div_stage_t dout
);

  div_stage_t dout_r;
  div_stage_t dout_nxt;

  function automatic div_lane_t lane_step(input div_lane_t l, input logic [10:0] size);
    logic [11:0] rem2;
    div_lane_t   o;
    rem2 = {l.rem[10:0], 1'b0};
    o    = l;
    if (rem2 >= {1'b0, size}) begin
      o.rem = rem2 - {1'b0, size};
      o.q   = {l.q[13:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.q   = {l.q[13:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    dout_nxt    = din;
    dout_nxt.sc = lane_step(din.sc, din.size);
    dout_nxt.tc = lane_step(din.tc, din.size);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule
`default_nettype wire

FILE: rtl/ncm_rsq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncm_rsq_cell
// Decides one bit of the reciprocal square root by an incremental square.
// ----------------------------------------------------------------------------
module ncm_rsq_cell
  import ncm_pkg::*;
#(
  parameter int BIT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rsq_stage_t din,
  output rsq_stage_t dout
);

  localparam logic [66:0] LIMIT = 67'd1 << 62;

  rsq_stage_t  dout_r;
  rsq_stage_t  dout_nxt;
  logic [66:0] cand;

  always_comb begin
    cand = {4'b0, din.p} + ({17'b0, din.rm} << (BIT + 1)) + ({35'b0, din.m} << (2 * BIT));
    dout_nxt = din;
    if (cand <= LIMIT) begin
      dout_nxt.p  = cand[62:0];
      dout_nxt.rm = din.rm + ({18'b0, din.m} << BIT);
      dout_nxt.r  = din.r | (17'd1 << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule
`default_nettype wire

FILE: rtl/normalization_cube_map_texel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normalization_cube_map_texel
// Computes the encoded unit direction of one cube map texel.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy stays low,
// so a new texel may be issued in every cycle. Each texel gives one result,
// shown for one cycle with out_valid high. The receiver cannot stall, so
// results leave in issue order at one per cycle.
// The pipeline is one input stage, fifteen division cells that form the
// face coordinates one quotient bit each, one stage that places and squares
// the vector, seventeen cells that settle one reciprocal root bit each, one
// multiply stage and the output register.
// The cube size register is written through the cfg channel, which is always
// ready; it should only change while no texel is in flight.
// Synchronous reset empties the pipeline and sets the cube size to 32.
// ----------------------------------------------------------------------------
module normalization_cube_map_texel
  import ncm_pkg::*;
#(
  parameter int MAX_CUBE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_face,
  input  logic [9:0]  in_col,
  input  logic [9:0]  in_row,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_bad_coord,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam logic [12:0] MAX_SZ = 13'(MAX_CUBE_SIZE);

  logic [10:0] cfg_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_size_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  logic [10:0] size_eff;
  logic [10:0] col_c;
  logic [10:0] row_c;
  logic        bad;
  logic [11:0] col_d;
  logic [11:0] row_d;
  div_stage_t  div_nxt;
  div_stage_t  div_s [0:DIV_CELLS];
  div_stage_t  div_r;

  always_comb begin
    if (cfg_size_r == 11'd0) begin
      size_eff = 11'd1;
    end else if ({2'b0, cfg_size_r} > MAX_SZ) begin
      size_eff = MAX_SZ[10:0];
    end else begin
      size_eff = cfg_size_r;
    end
    bad   = 1'b0;
    col_c = {1'b0, in_col};
    row_c = {1'b0, in_row};
    if ({1'b0, in_col} >= size_eff) begin
      col_c = size_eff - 11'd1;
      bad   = 1'b1;
    end
    if ({1'b0, in_row} >= size_eff) begin
      row_c = size_eff - 11'd1;
      bad   = 1'b1;
    end
    col_d            = {col_c[10:0], 1'b1};
    row_d            = {row_c[10:0], 1'b1};
    div_nxt.valid    = start && !busy;
    div_nxt.size     = size_eff;
    div_nxt.face     = in_face;
    div_nxt.bad      = bad;
    div_nxt.sc.q     = '0;
    div_nxt.tc.q     = '0;
    div_nxt.sc.neg   = col_d < {1'b0, size_eff};
    div_nxt.tc.neg   = row_d < {1'b0, size_eff};
    div_nxt.sc.rem   = div_nxt.sc.neg ? ({1'b0, size_eff} - col_d) : (col_d - {1'b0, size_eff});
    div_nxt.tc.rem   = div_nxt.tc.neg ? ({1'b0, size_eff} - row_d) : (row_d - {1'b0, size_eff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else begin
      div_r <= div_nxt;
    end
  end

  assign div_s[0] = div_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    ncm_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (div_s[i]),
      .dout (div_s[i+1])
    );
  end

  div_stage_t       dq;
  logic [15:0]      sc_m;
  logic [15:0]      tc_m;
  logic             sc_n;
  logic             tc_n;
  logic [2:0][15:0] v_mag;
  logic [2:0]       v_neg;
  rsq_stage_t       map_nxt;
  rsq_stage_t       map_r;
  rsq_stage_t       rsq_s [0:RSQ_CELLS];

  always_comb begin
    dq   = div_s[DIV_CELLS];
    sc_m = {1'b0, dq.sc.q};
    tc_m = {1'b0, dq.tc.q};
    sc_n = dq.sc.neg;
    tc_n = dq.tc.neg;
    unique case (dq.face)
      FACE_POS_X: begin
        v_mag = {sc_m, tc_m, AXIS_ONE};
        v_neg = {~sc_n, ~tc_n, 1'b0};
      end
      FACE_NEG_X: begin
        v_mag = {sc_m, tc_m, AXIS_ONE};
        v_neg = {sc_n, ~tc_n, 1'b1};
      end
      FACE_POS_Y: begin
        v_mag = {tc_m, AXIS_ONE, sc_m};
        v_neg = {tc_n, 1'b0, sc_n};
      end
      FACE_NEG_Y: begin
        v_mag = {tc_m, AXIS_ONE, sc_m};
        v_neg = {~tc_n, 1'b1, sc_n};
      end
      FACE_POS_Z: begin
        v_mag = {AXIS_ONE, tc_m, sc_m};
        v_neg = {1'b0, ~tc_n, sc_n};
      end
      FACE_NEG_Z: begin
        v_mag = {AXIS_ONE, tc_m, sc_m};
        v_neg = {1'b1, ~tc_n, ~sc_n};
      end
      default: begin
        v_mag = '0;
        v_neg = '0;
      end
    endcase
    map_nxt.valid = dq.valid;
    map_nxt.bad   = dq.bad;
    map_nxt.mag   = v_mag;
    map_nxt.neg   = v_neg;
    map_nxt.m     = 32'(32'(v_mag[0] * v_mag[0]) + 32'(v_mag[1] * v_mag[1])
                    + 32'(v_mag[2] * v_mag[2]));
    map_nxt.p     = '0;
    map_nxt.rm    = '0;
    map_nxt.r     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r.valid <= 1'b0;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign rsq_s[0] = map_r;

  for (genvar k = 0; k < RSQ_CELLS; k++) begin : g_rsq
    ncm_rsq_cell #(
      .BIT(RSQ_CELLS - 1 - k)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (rsq_s[k]),
      .dout (rsq_s[k+1])
    );
  end

  rsq_stage_t      rq;
  logic [2:0][7:0] enc_nxt;
  logic [32:0]     pr [0:2];
  logic [39:0]     pr127 [0:2];
  logic            enc_valid_r;
  logic            enc_bad_r;
  logic [2:0]      enc_neg_r;
  logic [2:0][7:0] enc_e_r;

  always_comb begin
    rq = rsq_s[RSQ_CELLS];
    for (int j = 0; j < 3; j++) begin
      pr[j]      = 33'(rq.mag[j] * rq.r);
      pr127[j]   = {pr[j], 7'b0} - {7'b0, pr[j]};
      enc_nxt[j] = pr127[j][38:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_valid_r <= 1'b0;
    end else begin
      enc_valid_r <= rq.valid;
    end
  end

  always_ff @(posedge clk) begin
    enc_bad_r <= rq.bad;
    enc_neg_r <= rq.neg;
    enc_e_r   <= enc_nxt;
  end

  logic       out_valid_r;
  logic [7:0] out_red_r;
  logic [7:0] out_green_r;
  logic [7:0] out_blue_r;
  logic       out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= enc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= enc_neg_r[0] ? (8'd128 - enc_e_r[0]) : (8'd128 + enc_e_r[0]);
    out_green_r <= enc_neg_r[1] ? (8'd128 - enc_e_r[1]) : (8'd128 + enc_e_r[1]);
    out_blue_r  <= enc_neg_r[2] ? (8'd128 - enc_e_r[2]) : (8'd128 + enc_e_r[2]);
    out_bad_r   <= enc_bad_r;
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_bad_coord = out_bad_r;

`ifndef SYNTHESIS
  a_bytes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red != 8'd0 && out_green != 8'd0 && out_blue != 8'd0))
    else $error("encoded component outside the unit range");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rsq_s[RSQ_CELLS].valid |-> rsq_s[RSQ_CELLS].r != 17'd0)
    else $error("reciprocal root resolved to zero");

  a_enc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rsq_s[RSQ_CELLS].valid |=> enc_valid_r ##1 out_valid)
    else $error("result lost between root and output");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/normalization_cube_map_texel_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalization_cube_map_texel_test
// Self-checking testbench for the normalization cube map texel pipeline.
// ----------------------------------------------------------------------------
// Texels are queued by an initial block and issued by a bursty driver at the
// falling edge. A monitor compares every result strobe with the encoded
// direction computed locally at issue time. The cube size is changed between
// phases, only after the pipeline has drained, and sweeps both extremes,
// zero, values above the maximum, and a fixed list of other sizes.
// ----------------------------------------------------------------------------
module normalization_cube_map_texel_test;
  import ncm_pkg::*;

  localparam int MAX_SIZE = 1024;
  localparam int PIPE_LAT = 36;

  typedef struct packed {
    logic [2:0] face;
    logic [9:0] col;
    logic [9:0] row;
  } texel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bad;
  } color_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_face = '0;
  logic [9:0]  in_col = '0;
  logic [9:0]  in_row = '0;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_bad_coord;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  texel_t pending_texels[$];
  color_t expected_colors[$];
  logic [10:0] cube_size_model = SIZE_RESET;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;

  normalization_cube_map_texel i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_face(in_face), .in_col(in_col), .in_row(in_row),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_bad_coord(out_bad_coord),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint signed center_q15(longint unsigned c, longint unsigned size);
    longint signed diff;
    longint unsigned mag;
    longint unsigned q;
    diff = longint'(2 * c + 1) - longint'(size);
    mag = (diff < 0) ? -diff : diff;
    q = (mag << 15) / size;
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned rsqrt_q16(longint unsigned m);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * m <= (64'd1 << 62)) r = t;
    end
    return r;
  endfunction

  function automatic logic [7:0] encode_byte(longint signed c, longint unsigned r);
    longint unsigned mag;
    longint unsigned e;
    mag = (c < 0) ? -c : c;
    e = (127 * mag * r) >> 31;
    return (c < 0) ? 8'(128 - e) : 8'(128 + e);
  endfunction

  function automatic color_t texel_color(texel_t t, logic [10:0] size_reg);
    color_t res;
    longint unsigned size;
    longint unsigned col;
    longint unsigned row;
    longint signed sc;
    longint signed tc;
    longint signed v[3];
    longint unsigned m;
    longint unsigned r;
    size = size_reg;
    res.bad = 1'b0;
    if (size == 0) size = 1;
    if (size > MAX_SIZE) size = MAX_SIZE;
    col = t.col;
    row = t.row;
    if (col >= size) begin col = size - 1; res.bad = 1'b1; end
    if (row >= size) begin row = size - 1; res.bad = 1'b1; end
    sc = center_q15(col, size);
    tc = center_q15(row, size);
    case (t.face)
      FACE_POS_X: begin v[0] = 32768;  v[1] = -tc;    v[2] = -sc;    end
      FACE_NEG_X: begin v[0] = -32768; v[1] = -tc;    v[2] = sc;     end
      FACE_POS_Y: begin v[0] = sc;     v[1] = 32768;  v[2] = tc;     end
      FACE_NEG_Y: begin v[0] = sc;     v[1] = -32768; v[2] = -tc;    end
      FACE_POS_Z: begin v[0] = sc;     v[1] = -tc;    v[2] = 32768;  end
      FACE_NEG_Z: begin v[0] = -sc;    v[1] = -tc;    v[2] = -32768; end
      default:    begin v[0] = 0;      v[1] = 0;      v[2] = 0;      end
    endcase
    if (t.face <= FACE_NEG_Z) begin
      m = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      r = rsqrt_q16(m);
    end else begin
      r = 0;
    end
    res.red = encode_byte(v[0], r);
    res.green = encode_byte(v[1], r);
    res.blue = encode_byte(v[2], r);
    return res;
  endfunction

  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      expected_colors.push_back(texel_color({in_face, in_col, in_row}, cube_size_model));
    end
    if (!rst_n || (start && busy)) begin
    end else if (pending_texels.size() > 0 && (burst_left > 0 || gap_left == 0)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      start <= 1'b1;
      {in_face, in_col, in_row} <= pending_texels.pop_front();
    end else begin
      start <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", {out_red, out_green,
          out_blue, out_bad_coord});
      end else begin
        want = expected_colors.pop_front();
        if (want != {out_red, out_green, out_blue, out_bad_coord}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected r%0d g%0d b%0d bad%0d, got r%0d g%0d b%0d bad%0d",
              want.red, want.green, want.blue, want.bad,
              out_red, out_green, out_blue, out_bad_coord);
        end
      end
    end
  end

  task automatic drain_pipe();
    while (pending_texels.size() > 0 || start || expected_colors.size() > 0)
      @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic set_cube_size(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cube_size_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int count, int size);
    texel_t t;
    int span;
    span = (size < 1) ? 1 : ((size > MAX_SIZE) ? MAX_SIZE : size);
    for (int i = 0; i < count; i++) begin
      t.face = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 9) == 0) begin
        t.col = 10'($urandom);
        t.row = 10'($urandom);
      end else begin
        t.col = 10'($urandom_range(0, span - 1));
        t.row = 10'($urandom_range(0, span - 1));
      end
      pending_texels.push_back(t);
    end
  endtask

  initial begin
    int sizes[12];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int f = 0; f < 8; f++) begin
      pending_texels.push_back({3'(f), 10'd0, 10'd0});
      pending_texels.push_back({3'(f), 10'd31, 10'd31});
    end
    pending_texels.push_back({FACE_POS_X, 10'd1023, 10'd5});
    pending_texels.push_back({FACE_NEG_Y, 10'd3, 10'd1023});
    pending_texels.push_back({FACE_POS_Z, 10'd32, 10'd32});
    pending_texels.push_back({FACE_NEG_Z, 10'd15, 10'd16});
    drain_pipe();
    sizes = '{1, 1024, 0, 2047, 1025, 2, 3, 1023, 17, 32, 640, 100};
    foreach (sizes[k]) begin
      set_cube_size(11'(sizes[k]));
      if (k == 0) begin
        pending_texels.push_back({FACE_POS_Y, 10'd0, 10'd1});
        pending_texels.push_back({FACE_NEG_X, 10'd1023, 10'd1023});
      end
      queue_random(150, (sizes[k] == 0) ? 1 : sizes[k]);
      drain_pipe();
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
